// ----- src/mts_pkg.sv -----
`timescale 1ns / 1ps

package mts_pkg;

    localparam int MTS_DEPTH = 64;
    localparam int ENTRY_W   = 34;
    localparam int VALUE_W   = 32;

    typedef logic [1:0]                t_func;
    typedef logic [1:0]                t_status;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [ENTRY_W-1:0] t_entry;

    localparam t_func FUNC_PUSH = 2'd0;
    localparam t_func FUNC_POP  = 2'd1;
    localparam t_func FUNC_MIN  = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_value VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_value  value;
        t_status status;
    } t_result;

endpackage

// ----- src/mts_if.sv -----
`timescale 1ns / 1ps

interface mts_in_if;
    import mts_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_value push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface mts_out_if;
    import mts_pkg::*;

    logic    valid;
    logic    ready;
    t_value  result_value;
    t_status status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ----- src/mts_mem.sv -----
`timescale 1ns / 1ps

module mts_mem #(
    parameter int DEPTH = mts_pkg::MTS_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  mts_pkg::t_entry       i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output mts_pkg::t_entry       o_rdata
);
    import mts_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mts_outq.sv -----
`timescale 1ns / 1ps

module mts_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mts_pkg::t_result i_item,
    output logic             o_full,
    mts_out_if.source        o_res
);
    import mts_pkg::*;

    t_result    r_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_pop;
    logic [1:0] w_wpos;

    assign w_pop  = o_res.valid && o_res.ready;
    assign w_wpos = r_cnt - {1'b0, w_pop};
    assign n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // shift first, then the new item lands behind whatever remains
    always_ff @(posedge i_clk) begin
        if (i_push && (w_wpos[0] == 1'b0)) begin
            r_q[0] <= i_item;
        end else if (w_pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && w_wpos[0]) begin
            r_q[1] <= i_item;
        end
    end

    assign o_full             = r_cnt[1];
    assign o_res.valid        = (r_cnt != 2'd0);
    assign o_res.result_value = r_q[0].value;
    assign o_res.status       = r_q[0].status;

endmodule

// ----- src/min_tracking_stack_unit.sv -----
`timescale 1ns / 1ps

// channel  | dir | fields                  | notes
// ---------+-----+-------------------------+-------------------------------
// i_cmd    | in  | func, push_value        | push, pop or minimum query
// o_res    | out | result_value, status    | one item per command, in order
//
// Push, query and error commands finish in the accept cycle; a pop finishes
// in S_POP because the top entry comes from the entry memory's registered read.
// A two-deep result queue holds finished items; commands are taken outside
// S_POP while it has room, so a stalled sink blocks i_cmd only after two results pile up.
// Reset: synchronous, active low; empties the stack and sets the minimum to
// the largest signed value. Entry memory contents are not cleared.

module min_tracking_stack_unit #(
    parameter int DEPTH = mts_pkg::MTS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_in_if.sink    i_cmd,
    mts_out_if.source o_res
);
    import mts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    t_value        r_min, n_min;

    logic          w_acc;
    logic          w_full;
    logic          w_empty;
    logic          w_stack_full;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_re;
    logic [FW-1:0] w_fill_m1;
    t_entry        w_rdata;
    t_entry        w_min_ext;
    t_entry        w_x_ext;
    t_entry        w_restore;
    logic          w_qpush;
    t_result       w_item;

    assign w_empty      = (r_fill == '0);
    assign w_stack_full = (r_fill >= FW'(DEPTH));
    assign w_fill_m1    = r_fill - 1'b1;
    assign i_cmd.ready  = (r_state == S_IDLE) && !w_full;
    assign w_acc        = i_cmd.valid && i_cmd.ready;
    assign w_min_ext    = {{(ENTRY_W-VALUE_W){r_min[VALUE_W-1]}}, r_min};
    assign w_x_ext      = {{(ENTRY_W-VALUE_W){i_cmd.push_value[VALUE_W-1]}},
                           i_cmd.push_value};
    assign w_restore    = {w_min_ext[ENTRY_W-2:0], 1'b0} - w_rdata;
    assign w_waddr      = r_fill[AW-1:0];
    assign w_re         = w_acc && (i_cmd.func == FUNC_POP) && !w_empty;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_min   = r_min;
        w_we    = 1'b0;
        w_wdata = w_x_ext;
        w_qpush = 1'b0;
        w_item  = '{value: '0, status: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_cmd.func)
                        FUNC_PUSH: begin
                            w_qpush = 1'b1;
                            if (w_stack_full) begin
                                w_item.status = ST_FULL;
                            end else begin
                                w_we   = 1'b1;
                                n_fill = r_fill + 1'b1;
                                if (w_empty) begin
                                    n_min = i_cmd.push_value;
                                end else if (i_cmd.push_value < r_min) begin
                                    // marked entry: 2x - min sits below the new minimum
                                    w_wdata = {w_x_ext[ENTRY_W-2:0], 1'b0} - w_min_ext;
                                    n_min   = i_cmd.push_value;
                                end
                            end
                        end
                        FUNC_POP: begin
                            if (w_empty) begin
                                w_qpush       = 1'b1;
                                w_item.status = ST_EMPTY;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        FUNC_MIN: begin
                            w_qpush = 1'b1;
                            if (w_empty) begin
                                w_item.status = ST_EMPTY;
                            end else begin
                                w_item.value = r_min;
                            end
                        end
                        default: begin
                            w_qpush = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                w_qpush = 1'b1;
                n_fill  = w_fill_m1;
                n_state = S_IDLE;
                if (w_rdata >= w_min_ext) begin
                    w_item.value = w_rdata[VALUE_W-1:0];
                end else begin
                    w_item.value = r_min;
                    n_min        = w_restore[VALUE_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_min   <= VALUE_MAX;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_min   <= n_min;
        end
    end

    mts_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_fill_m1[AW-1:0]),
        .o_rdata (w_rdata)
    );

    mts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .i_item  (w_item),
        .o_full  (w_full),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_pop_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(w_re))
        else $error("pop state entered without a memory read");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond depth");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_cmd.func == FUNC_PUSH) && w_stack_full)
            |=> ($stable(r_fill) && $stable(r_min)))
        else $error("push on full stack changed state");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("pop did not shrink the stack");
`endif

endmodule
